/* src/isort_pkg.sv */
// Package for the insertion sorter: beat payload types, the link between
// neighboring cells, the controller state type and default sizes.
// No dependencies.
package isort_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int VALUE_W = 32;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic last;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sorted_value;
		logic final_res;
		logic overflow;
	} result_t;

	typedef struct packed {
		logic valid;
		logic gt;
		logic signed [VALUE_W-1:0] value;
	} cell_link_t;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} sort_state_t;

endpackage

/* src/isort_cell.sv */
// One cell of the insertion chain: holds one value and its valid bit.
// Depends on isort_pkg for the neighbor link type.
module isort_cell import isort_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic ins_en,
	input  logic shift_en,
	input  logic signed [VALUE_W-1:0] ins_value,
	input  cell_link_t left,
	input  cell_link_t right,
	output cell_link_t link
);

	logic valid_q;
	logic signed [VALUE_W-1:0] value_q;
	logic gt;
	logic take;

	assign gt = valid_q && (value_q > ins_value);
	// A cell changes on insertion when its value moves right or it is the first free slot.
	assign take = gt || (!valid_q && left.valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= right.valid;
		end else if (ins_en && take) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			value_q <= right.value;
		end else if (ins_en && take) begin
			value_q <= left.gt ? left.value : ins_value;
		end
	end

	assign link = '{valid: valid_q, gt: gt, value: value_q};

endmodule

/* src/insertion_sorter_unit.sv */
// Insertion sorter top level: a chain of isort_cell instances and the drain control.
// Depends on isort_pkg and isort_cell.
//
// The item channel takes one signed value per beat; the beat with last set
// closes the set. Every cell compares its value with the incoming one in
// parallel, so while a set is being filled one beat is taken every cycle.
// Equal values keep their arrival order. Values beyond CAPACITY are dropped.
// After the closing beat the chain shifts toward its head once per cycle and
// the result channel emits the held values in ascending order, one per beat,
// final_res on the last and overflow on all of them if anything was dropped.
// result_valid rises after the closing beat has put the controller into
// ST_DRAIN and the head value is loaded into the result register. While the
// chain drains, item_stall is high. A stalled result holds in the output
// register and stops the drain. Once the last result is loaded the chain is
// empty and the next set may start, even while that result waits.
// Reset empties the chain and clears the result register's valid.
module insertion_sorter_unit import isort_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  item_t item,
	output logic result_valid,
	input  logic result_stall,
	output result_t result
);

	cell_link_t links [CAPACITY];
	logic [CAPACITY-1:0] valid_vec;
	sort_state_t state_q, state_next;
	logic dropped_q;
	logic res_valid_q;
	result_t res_q;
	logic accept;
	logic full;
	logic ins_en;
	logic emit;
	logic emit_final;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_link_t left_link;
		cell_link_t right_link;
		if (i == 0) begin : g_head
			assign left_link = '{valid: 1'b1, gt: 1'b0, value: '0};
		end else begin : g_mid
			assign left_link = links[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_link = '{valid: 1'b0, gt: 1'b0, value: '0};
		end else begin : g_body
			assign right_link = links[i+1];
		end
		isort_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ins_en    (ins_en),
			.shift_en  (emit),
			.ins_value (item.value),
			.left      (left_link),
			.right     (right_link),
			.link      (links[i])
		);
		assign valid_vec[i] = links[i].valid;
	end

	assign full = links[CAPACITY-1].valid;
	assign accept = item_valid && !item_stall;
	assign ins_en = accept && !full;
	assign emit_final = !links[1].valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		item_stall = 1'b0;
		emit = 1'b0;
		unique case (state_q)
			ST_FILL: begin
				if (accept && item.last) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				item_stall = 1'b1;
				emit = !res_valid_q || !result_stall;
				if (emit && emit_final) begin
					state_next = ST_FILL;
				end
			end
			default: begin
				state_next = ST_FILL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dropped_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept && full) begin
				dropped_q <= 1'b1;
			end else if (emit && emit_final) begin
				dropped_q <= 1'b0;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= '{sorted_value: links[0].value, final_res: emit_final,
				overflow: dropped_q};
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

`ifndef SYNTH
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec & (valid_vec + 1'b1)) == '0))
		else $error("held values are not packed at the head of the chain");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> valid_vec[0])
		else $error("draining an empty chain");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_final) |=> (state_q == ST_FILL) && !dropped_q && (valid_vec == '0))
		else $error("chain not cleared after the final result");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ins_en |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
		else $error("insertion did not add exactly one held value");
`endif

endmodule
